// File: src/rcsg_pkg.sv
// shared types, constants and elaboration-time helpers for the rope cos/sin generator
// no dependencies; imported by every module of the block
package rcsg_pkg;

    // configuration register indexes
    localparam logic CFG_ROPE_DIM  = 1'b0;
    localparam logic CFG_LOG2_BASE = 1'b1;

    localparam logic [7:0]  ROPE_DIM_RESET  = 8'd32;
    localparam logic [23:0] LOG2_BASE_RESET = 24'd870823;

    // fixed point constants
    localparam logic [30:0] ONE_Q30        = 31'h4000_0000;
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
    localparam logic [31:0] TWO_PI_Q29     = 32'd3373259426;

    // exponent divider: 40 quotient bits, 4 per stage
    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = 10;
    localparam int EXP_STAGES = 24;

    // horner divisors of the truncated taylor series
    localparam int HORNER_STEPS = 6;
    localparam int SIN_DIV [HORNER_STEPS] = '{156, 110, 72, 42, 20, 6};
    localparam int COS_DIV [HORNER_STEPS] = '{182, 132, 90, 56, 30, 12};

    // quadrant codes
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // sideband that travels with an item through the pipeline
    typedef struct packed {
        logic        oor;
        logic [11:0] pos;
        logic        huge;
        logic [5:0]  shamt;
        logic [1:0]  quad;
    } tag_t;

    typedef struct packed {
        logic              oor;
        logic signed [15:0] sin_v;
        logic signed [15:0] cos_v;
    } res_t;

    // floor square root, bit by bit
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        rem  = v;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // 2^(-2^-k) in q1.30 by repeated square roots
    function automatic logic [29:0] exp_coef(input int k);
        logic [63:0] c;
        c = 64'd1 << 29;
        for (int j = 1; j <= k; j++) begin
            c = isqrt64(c << 30);
        end
        return c[29:0];
    endfunction

    // corrects a reciprocal quotient estimate that may be one short
    function automatic logic [29:0] div_fix(input logic [31:0] y, input logic [29:0] q0,
                                           input logic [7:0] dv);
        logic [37:0] prod;
        logic [31:0] rm;
        prod = 38'(q0) * 38'(dv);
        rm   = y - prod[31:0];
        return (rm >= 32'(dv)) ? q0 + 30'd1 : q0;
    endfunction

    // q1.30 (non-negative) to q1.15 with rounding and saturation at one
    function automatic logic signed [15:0] to_q15(input logic [31:0] v);
        logic [32:0] s;
        s = 33'(v) + 33'd16384;
        return (s[32:15] > 18'd32767) ? 16'sd32767 : signed'(s[30:15]);
    endfunction

endpackage

// File: src/rcsg_exp2.sv
// pipelined 2^-f for a q0.24 fraction f, result in q1.30, one bit of f per stage
// depends on rcsg_pkg
module rcsg_exp2 (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          ce,
    input  logic          in_valid,
    input  logic [23:0]   in_frac,
    input  rcsg_pkg::tag_t in_tag,
    output logic          out_valid,
    output logic [30:0]   out_mant,
    output rcsg_pkg::tag_t out_tag
);
    import rcsg_pkg::*;

    logic [30:0] mant_reg [1:EXP_STAGES];
    logic [23:0] frac_reg [1:EXP_STAGES];
    tag_t        tag_reg  [1:EXP_STAGES];
    logic        val_reg  [1:EXP_STAGES];

    for (genvar k = 1; k <= EXP_STAGES; k++) begin : g_stage
        localparam logic [29:0] COEF = exp_coef(k);
        logic [30:0] m_prev;
        logic [23:0] f_prev;
        tag_t        t_prev;
        logic        v_prev;
        logic [60:0] prod;

        if (k == 1) begin : g_first
            assign m_prev = ONE_Q30;
            assign f_prev = in_frac;
            assign t_prev = in_tag;
            assign v_prev = in_valid;
        end else begin : g_rest
            assign m_prev = mant_reg[k-1];
            assign f_prev = frac_reg[k-1];
            assign t_prev = tag_reg[k-1];
            assign v_prev = val_reg[k-1];
        end

        assign prod = 61'(m_prev) * 61'(COEF);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                val_reg[k] <= 1'b0;
            end else if (ce) begin
                val_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                mant_reg[k] <= f_prev[EXP_STAGES-k] ? prod[60:30] : m_prev;
                frac_reg[k] <= f_prev;
                tag_reg[k]  <= t_prev;
            end
        end
    end

    assign out_valid = val_reg[EXP_STAGES];
    assign out_mant  = mant_reg[EXP_STAGES];
    assign out_tag   = tag_reg[EXP_STAGES];

endmodule

// File: src/rcsg_sincos.sv
// pipelined quarter-turn sin/cos by horner series, quadrant fold and q1.15 output
// depends on rcsg_pkg
module rcsg_sincos (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           ce,
    input  logic           in_valid,
    input  logic [30:0]    in_x,
    input  rcsg_pkg::tag_t in_tag,
    output logic           out_valid,
    output rcsg_pkg::res_t out_res
);
    import rcsg_pkg::*;

    logic        hval_reg [0:HORNER_STEPS];
    logic [30:0] hx_reg   [0:HORNER_STEPS];
    logic [31:0] hx2_reg  [0:HORNER_STEPS];
    logic [30:0] hts_reg  [0:HORNER_STEPS];
    logic [30:0] htc_reg  [0:HORNER_STEPS];
    tag_t        htag_reg [0:HORNER_STEPS];

    logic [61:0] sq_prod;
    assign sq_prod = 62'(in_x) * 62'(in_x);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hval_reg[0] <= 1'b0;
        end else if (ce) begin
            hval_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            hx_reg[0]   <= in_x;
            hx2_reg[0]  <= sq_prod[61:30];
            hts_reg[0]  <= ONE_Q30;
            htc_reg[0]  <= ONE_Q30;
            htag_reg[0] <= in_tag;
        end
    end

    // each step: multiply, reciprocal multiply, correct and subtract from one
    for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_horner
        localparam int unsigned SDIV = SIN_DIV[k];
        localparam int unsigned CDIV = COS_DIV[k];
        localparam logic [63:0] SR64 = (64'd1 << 32) / SDIV;
        localparam logic [63:0] CR64 = (64'd1 << 32) / CDIV;
        localparam logic [29:0] SRCP = SR64[29:0];
        localparam logic [29:0] CRCP = CR64[29:0];

        logic        a_val_reg, b_val_reg;
        logic [30:0] a_x_reg, b_x_reg;
        logic [31:0] a_x2_reg, b_x2_reg;
        tag_t        a_tag_reg, b_tag_reg;
        logic [31:0] a_ys_reg, a_yc_reg, b_ys_reg, b_yc_reg;
        logic [29:0] b_qs_reg, b_qc_reg;
        logic [62:0] ps, pc;
        logic [61:0] ms, mc;

        assign ps = 63'(hx2_reg[k]) * 63'(hts_reg[k]);
        assign pc = 63'(hx2_reg[k]) * 63'(htc_reg[k]);
        assign ms = 62'(a_ys_reg) * 62'(SRCP);
        assign mc = 62'(a_yc_reg) * 62'(CRCP);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                a_val_reg       <= 1'b0;
                b_val_reg       <= 1'b0;
                hval_reg[k+1]   <= 1'b0;
            end else if (ce) begin
                a_val_reg       <= hval_reg[k];
                b_val_reg       <= a_val_reg;
                hval_reg[k+1]   <= b_val_reg;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                a_x_reg       <= hx_reg[k];
                a_x2_reg      <= hx2_reg[k];
                a_tag_reg     <= htag_reg[k];
                a_ys_reg      <= ps[61:30];
                a_yc_reg      <= pc[61:30];
                b_x_reg       <= a_x_reg;
                b_x2_reg      <= a_x2_reg;
                b_tag_reg     <= a_tag_reg;
                b_ys_reg      <= a_ys_reg;
                b_yc_reg      <= a_yc_reg;
                b_qs_reg      <= ms[61:32];
                b_qc_reg      <= mc[61:32];
                hx_reg[k+1]   <= b_x_reg;
                hx2_reg[k+1]  <= b_x2_reg;
                htag_reg[k+1] <= b_tag_reg;
                hts_reg[k+1]  <= ONE_Q30 - {1'b0, div_fix(b_ys_reg, b_qs_reg, 8'(SDIV))};
                htc_reg[k+1]  <= ONE_Q30 - {1'b0, div_fix(b_yc_reg, b_qc_reg, 8'(CDIV))};
            end
        end
    end

    // final products: sin = x*t, cos term = x2*t/2
    logic        f1_val_reg;
    logic [30:0] f1_s_reg;
    logic [30:0] f1_p_reg;
    tag_t        f1_tag_reg;
    logic [61:0] fs_prod;
    logic [62:0] fc_prod;

    assign fs_prod = 62'(hx_reg[HORNER_STEPS]) * 62'(hts_reg[HORNER_STEPS]);
    assign fc_prod = 63'(hx2_reg[HORNER_STEPS]) * 63'(htc_reg[HORNER_STEPS]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_val_reg <= 1'b0;
        end else if (ce) begin
            f1_val_reg <= hval_reg[HORNER_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            f1_s_reg   <= fs_prod[60:30];
            f1_p_reg   <= fc_prod[61:31];
            f1_tag_reg <= htag_reg[HORNER_STEPS];
        end
    end

    logic signed [15:0] s_q, c_q;
    res_t               res_next;
    logic               val_reg;
    res_t               res_reg;

    always_comb begin
        s_q = to_q15(32'(f1_s_reg));
        // cos clamps at zero when the last term reaches one
        c_q = (f1_p_reg >= ONE_Q30) ? 16'sd0 : to_q15(32'(ONE_Q30 - f1_p_reg));
        res_next.oor = f1_tag_reg.oor;
        case (f1_tag_reg.quad)
            QUAD_0: begin
                res_next.cos_v = c_q;
                res_next.sin_v = s_q;
            end
            QUAD_1: begin
                res_next.cos_v = -s_q;
                res_next.sin_v = c_q;
            end
            QUAD_2: begin
                res_next.cos_v = -c_q;
                res_next.sin_v = -s_q;
            end
            default: begin
                res_next.cos_v = s_q;
                res_next.sin_v = -c_q;
            end
        endcase
        if (f1_tag_reg.oor) begin
            res_next.cos_v = 16'sd0;
            res_next.sin_v = 16'sd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val_reg <= 1'b0;
        end else if (ce) begin
            val_reg <= f1_val_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = val_reg;
    assign out_res   = res_reg;

endmodule

// File: src/rope_cos_sin_generator_top.sv
// top level of the rope cos/sin generator: exponent divider, angle datapath, output skid
// depends on rcsg_pkg, rcsg_exp2 and rcsg_sincos
//
// usage
//  - input stream s_*: one transfer per table entry, s_tdata holds position and pair index
//  - result stream m_*: one transfer per input, m_tdata holds cos and sin in signed q1.15,
//    m_tuser flags an entry outside the table (pair index not below half the rope
//    dimension), and then both values are zero
//  - config port: cfg_wr_en writes cfg_wdata into register cfg_index at the clock edge
//    (0 = rope dimension, 1 = log2_base q8.16); write only while no item is in flight
//  - throughput: one item per cycle unless stalled, every stage is a register and nothing iterates
//  - pipeline from input transfer to result valid: input register, 10 divider
//    stages (4 quotient bits each), 24 exp2 stages (one fraction bit each), 4 angle
//    stages, squaring, 18 horner stages (3 per series term) and 2 output stages
//  - stall: the whole pipeline freezes only while the skid register holds a result,
//    so s_tready drops in the cycle after m_tready is low with a result waiting
//  - reset: aresetn low clears all valid flags and the skid, and loads a rope
//    dimension of 32 and log2_base = 870823
//
module rope_cos_sin_generator_top (
    input  logic        aclk,
    input  logic        aresetn,
    // config write port
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [23:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [11:0] position, [17:12] pair_index, [23:18] zero
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] cos_value, [31:16] sin_value
    output logic        m_tuser    // [0] index_out_of_range
);
    import rcsg_pkg::*;

    // configuration registers
    logic [7:0]  rope_dim_reg;
    logic [23:0] log2_base_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rope_dim_reg  <= ROPE_DIM_RESET;
            log2_base_reg <= LOG2_BASE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ROPE_DIM:  rope_dim_reg  <= cfg_wdata[7:0];
                CFG_LOG2_BASE: log2_base_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline advances unless the skid holds a result
    logic skid_valid_reg;
    logic ce;
    assign ce       = ~skid_valid_reg;
    assign s_tready = ~skid_valid_reg;

    // input stage: numerator 2i * log2_base, range check
    logic [11:0] in_pos;
    logic [5:0]  in_pair;
    logic [7:0]  dim_even;
    logic [30:0] num_next;
    tag_t        in_tag;

    assign in_pos   = s_tdata[11:0];
    assign in_pair  = s_tdata[17:12];
    assign dim_even = {rope_dim_reg[7:1], 1'b0};
    assign num_next = 31'({in_pair, 1'b0}) * 31'(log2_base_reg);

    always_comb begin
        in_tag       = '0;
        in_tag.pos   = in_pos;
        // covers a zero dimension too
        in_tag.oor   = ({1'b0, in_pair} >= rope_dim_reg[7:1]);
    end

    // exponent divider: E = (num << 8) / d, restoring, DIV_BITS quotient bits per stage
    logic        dval_reg [0:DIV_STAGES];
    logic [39:0] dnum_reg [0:DIV_STAGES];
    logic [39:0] dquo_reg [0:DIV_STAGES];
    logic [7:0]  drem_reg [0:DIV_STAGES];
    tag_t        dtag_reg [0:DIV_STAGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dval_reg[0] <= 1'b0;
        end else if (ce) begin
            dval_reg[0] <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            dnum_reg[0] <= {1'b0, num_next, 8'd0};
            dquo_reg[0] <= '0;
            drem_reg[0] <= '0;
            dtag_reg[0] <= in_tag;
        end
    end

    for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_div
        logic [39:0] num_c;
        logic [39:0] quo_c;
        logic [7:0]  rem_c;
        logic [8:0]  trial;

        always_comb begin
            num_c = dnum_reg[s-1];
            quo_c = dquo_reg[s-1];
            rem_c = drem_reg[s-1];
            trial = '0;
            for (int b = 0; b < DIV_BITS; b++) begin
                trial = {rem_c, num_c[39]};
                num_c = {num_c[38:0], 1'b0};
                if (trial >= {1'b0, dim_even}) begin
                    trial = trial - {1'b0, dim_even};
                    quo_c = {quo_c[38:0], 1'b1};
                end else begin
                    quo_c = {quo_c[38:0], 1'b0};
                end
                rem_c = trial[7:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dval_reg[s] <= 1'b0;
            end else if (ce) begin
                dval_reg[s] <= dval_reg[s-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                dnum_reg[s] <= num_c;
                dquo_reg[s] <= quo_c;
                drem_reg[s] <= rem_c;
                dtag_reg[s] <= dtag_reg[s-1];
            end
        end
    end

    // split exponent: integer part is a right shift, fraction goes to exp2
    logic [39:0] expo;
    tag_t        exp_in_tag;

    assign expo = dquo_reg[DIV_STAGES];

    always_comb begin
        exp_in_tag       = dtag_reg[DIV_STAGES];
        exp_in_tag.huge  = |expo[39:30];
        exp_in_tag.shamt = expo[29:24];
    end

    logic        ex_valid;
    logic [30:0] ex_mant;
    tag_t        ex_tag;

    rcsg_exp2 u_exp2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (dval_reg[DIV_STAGES]),
        .in_frac   (expo[23:0]),
        .in_tag    (exp_in_tag),
        .out_valid (ex_valid),
        .out_mant  (ex_mant),
        .out_tag   (ex_tag)
    );

    // angle path: turns per position, times position, shift, phase to radians
    logic        t_val_reg, a_val_reg, p_val_reg, x_val_reg;
    logic [37:0] turns_reg;
    logic [49:0] acc_reg;
    logic [31:0] phase_reg;
    logic [30:0] x_reg;
    tag_t        t_tag_reg, a_tag_reg, p_tag_reg, x_tag_reg;
    tag_t        x_tag_next;

    logic [60:0] turns_prod;
    logic [49:0] acc_prod;
    logic [49:0] acc_shift;
    logic [61:0] rad_prod;

    assign turns_prod = 61'(ex_mant) * 61'(INV_TWO_PI_Q32);
    assign acc_prod   = 50'(t_tag_reg.pos) * 50'(turns_reg);
    assign acc_shift  = acc_reg >> a_tag_reg.shamt;
    assign rad_prod   = 62'(phase_reg[29:0]) * 62'(TWO_PI_Q29);

    // quadrant comes from the top phase bits
    always_comb begin
        x_tag_next      = p_tag_reg;
        x_tag_next.quad = phase_reg[31:30];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_val_reg <= 1'b0;
            a_val_reg <= 1'b0;
            p_val_reg <= 1'b0;
            x_val_reg <= 1'b0;
        end else if (ce) begin
            t_val_reg <= ex_valid;
            a_val_reg <= t_val_reg;
            p_val_reg <= a_val_reg;
            x_val_reg <= p_val_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            turns_reg <= turns_prod[59:22];
            t_tag_reg <= ex_tag;
            acc_reg   <= acc_prod;
            a_tag_reg <= t_tag_reg;
            // a huge exponent leaves a zero angle
            phase_reg <= a_tag_reg.huge ? 32'd0 : acc_shift[39:8];
            p_tag_reg <= a_tag_reg;
            x_reg     <= rad_prod[61:31];
            x_tag_reg <= x_tag_next;
        end
    end

    logic res_valid;
    res_t res;

    rcsg_sincos u_sincos (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (x_val_reg),
        .in_x      (x_reg),
        .in_tag    (x_tag_reg),
        .out_valid (res_valid),
        .out_res   (res)
    );

    // output skid: catches the last stage when the receiver stalls
    res_t skid_reg;
    res_t out_sel;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else if (!skid_valid_reg) begin
            skid_valid_reg <= res_valid & ~m_tready;
        end else if (m_tready) begin
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!skid_valid_reg) begin
            skid_reg <= res;
        end
    end

    assign out_sel  = skid_valid_reg ? skid_reg : res;
    assign m_tvalid = skid_valid_reg | res_valid;
    assign m_tdata  = {out_sel.sin_v, out_sel.cos_v};
    assign m_tuser  = out_sel.oor;

endmodule
